### rtl/s256_pkg.sv
// ----------------------------------------------------------------------------
// s256_pkg
// Shared types, round constants and initial hash values for the SHA-256 hasher.
// ----------------------------------------------------------------------------
`default_nettype none

package s256_pkg;

  typedef logic [31:0] word_t;
  typedef word_t [7:0] hvec_t;   // index 0 is working variable a / H0

  localparam int unsigned BufWords = 16;
  localparam int unsigned Rounds   = 64;
  localparam int unsigned LenStart = 56;
  localparam logic [7:0]  PadByte  = 8'h80;
  localparam logic [63:0] BlockBits = 64'd512;

  localparam hvec_t InitHash = '{
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  localparam word_t [63:0] RoundK = '{
    32'hc67178f2, 32'hbef9a3f7, 32'ha4506ceb, 32'h90befffa,
    32'h8cc70208, 32'h84c87814, 32'h78a5636f, 32'h748f82ee,
    32'h682e6ff3, 32'h5b9cca4f, 32'h4ed8aa4a, 32'h391c0cb3,
    32'h34b0bcb5, 32'h2748774c, 32'h1e376c08, 32'h19a4c116,
    32'h106aa070, 32'hf40e3585, 32'hd6990624, 32'hd192e819,
    32'hc76c51a3, 32'hc24b8b70, 32'ha81a664b, 32'ha2bfe8a1,
    32'h92722c85, 32'h81c2c92e, 32'h766a0abb, 32'h650a7354,
    32'h53380d13, 32'h4d2c6dfc, 32'h2e1b2138, 32'h27b70a85,
    32'h14292967, 32'h06ca6351, 32'hd5a79147, 32'hc6e00bf3,
    32'hbf597fc7, 32'hb00327c8, 32'ha831c66d, 32'h983e5152,
    32'h76f988da, 32'h5cb0a9dc, 32'h4a7484aa, 32'h2de92c6f,
    32'h240ca1cc, 32'h0fc19dc6, 32'hefbe4786, 32'he49b69c1,
    32'hc19bf174, 32'h9bdc06a7, 32'h80deb1fe, 32'h72be5d74,
    32'h550c7dc3, 32'h243185be, 32'h12835b01, 32'hd807aa98,
    32'hab1c5ed5, 32'h923f82a4, 32'h59f111f1, 32'h3956c25b,
    32'he9b5dba5, 32'hb5c0fbcf, 32'h71374491, 32'h428a2f98
  };

  function automatic word_t rotr(input word_t x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

endpackage

`default_nettype wire

### rtl/s256_round.sv
// ----------------------------------------------------------------------------
// s256_round
// One SHA-256 compression round and the matching message schedule word.
// ----------------------------------------------------------------------------
`default_nettype none

module s256_round (
  input  s256_pkg::hvec_t       v_in,
  input  s256_pkg::word_t [15:0] win,
  input  logic                  use_mem,
  input  s256_pkg::word_t       mem_word,
  input  s256_pkg::word_t       k,
  output s256_pkg::word_t       w_out,
  output s256_pkg::hvec_t       v_out
);
  import s256_pkg::*;

  word_t s0, s1, sched, big0, big1, chs, mj, t1, t2;

  always_comb begin
    // Window entry 15 holds w[t-1], entry 0 holds w[t-16].
    s0    = rotr(win[1], 7) ^ rotr(win[1], 18) ^ (win[1] >> 3);
    s1    = rotr(win[14], 17) ^ rotr(win[14], 19) ^ (win[14] >> 10);
    sched = s1 + win[9] + s0 + win[0];
    w_out = use_mem ? mem_word : sched;

    big1 = rotr(v_in[4], 6) ^ rotr(v_in[4], 11) ^ rotr(v_in[4], 25);
    chs  = (v_in[4] & v_in[5]) ^ (~v_in[4] & v_in[6]);
    t1   = v_in[7] + big1 + chs + k + w_out;
    big0 = rotr(v_in[0], 2) ^ rotr(v_in[0], 13) ^ rotr(v_in[0], 22);
    mj   = (v_in[0] & v_in[1]) ^ (v_in[0] & v_in[2]) ^ (v_in[1] & v_in[2]);
    t2   = big0 + mj;

    v_out[7] = v_in[6];
    v_out[6] = v_in[5];
    v_out[5] = v_in[4];
    v_out[4] = v_in[3] + t1;
    v_out[3] = v_in[2];
    v_out[2] = v_in[1];
    v_out[1] = v_in[0];
    v_out[0] = t1 + t2;
  end

endmodule

`default_nettype wire

### rtl/sha256_stream_hasher.sv
// ----------------------------------------------------------------------------
// sha256_stream_hasher
// SHA-256 over a byte stream, with the block buffer held in a word memory.
// ----------------------------------------------------------------------------
// Data request: the 64th byte of a block starts a compression (a load step,
// 64 rounds, an update step); input is stalled until the compression is done.
// Finish request: the rest of the block is padded a byte at a time, length bytes
// included; an idle step and a compression first when the length does not fit.
// The final compression is followed by eight digest words, one per accepted cycle.
// Synchronous active-low reset clears the control state and restores the hash.
`default_nettype none

module sha256_stream_hasher (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_kind,
  input  logic [7:0]          in_data_byte,
  output logic                out_valid,
  input  logic                out_stall,
  output s256_pkg::word_t     out_digest_word,
  output logic [2:0]          out_word_index,
  output logic                out_last
);
  import s256_pkg::*;

  // Sequencer states.
  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StPad  = 3'd1;
  localparam logic [2:0] StLoad = 3'd2;
  localparam logic [2:0] StComp = 3'd3;
  localparam logic [2:0] StFold = 3'd4;
  localparam logic [2:0] StOut  = 3'd5;

  // Where the sequencer goes once a compression has been folded in.
  localparam logic [1:0] RetIdle = 2'd0;
  localparam logic [1:0] RetPad  = 2'd1;
  localparam logic [1:0] RetOut  = 2'd2;

  // The block buffer: sixteen big-endian words, written a byte at a time.
  word_t buf_mem [BufWords];
  word_t rd_q;
  logic  rd_en;
  logic [3:0] rd_addr;
  logic  wr_en;
  logic [5:0] wr_pos;
  logic [7:0] wr_byte;

  logic [2:0]  state_r, state_nxt;
  logic [1:0]  ret_r, ret_nxt;
  logic [5:0]  fill_r, fill_nxt;
  logic [63:0] total_r, total_nxt;
  logic [63:0] len_r, len_nxt;
  logic [6:0]  pos_r, pos_nxt;
  logic        extra_r, extra_nxt;
  logic [5:0]  rnd_r, rnd_nxt;
  logic [2:0]  idx_r, idx_nxt;
  logic        ovalid_r, ovalid_nxt;
  hvec_t       h_r, h_nxt;
  hvec_t       v_r, v_nxt;
  word_t [15:0] win_r, win_nxt;

  word_t w_t;
  hvec_t v_rnd;
  logic  in_acc;
  logic [2:0] len_sel;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      buf_mem[wr_pos[5:2]][{~wr_pos[1:0], 3'b000} +: 8] <= wr_byte;
    end
    if (rd_en) begin
      rd_q <= buf_mem[rd_addr];
    end
  end

  s256_round u_round (
    .v_in     (v_r),
    .win      (win_r),
    .use_mem  (rnd_r < 6'(BufWords)),
    .mem_word (rd_q),
    .k        (RoundK[rnd_r]),
    .w_out    (w_t),
    .v_out    (v_rnd)
  );

  assign in_stall        = (state_r != StIdle);
  assign in_acc          = in_valid && !in_stall;
  assign out_valid       = ovalid_r;
  assign out_digest_word = h_r[idx_r];
  assign out_word_index  = idx_r;
  assign out_last        = (idx_r == 3'd7);

  // Length bytes go out most significant first at positions 56 to 63.
  assign len_sel = ~pos_r[2:0];

  always_comb begin
    state_nxt  = state_r;
    ret_nxt    = ret_r;
    fill_nxt   = fill_r;
    total_nxt  = total_r;
    len_nxt    = len_r;
    pos_nxt    = pos_r;
    extra_nxt  = extra_r;
    rnd_nxt    = rnd_r;
    idx_nxt    = idx_r;
    ovalid_nxt = ovalid_r;
    h_nxt      = h_r;
    v_nxt      = v_r;
    win_nxt    = win_r;
    wr_en      = 1'b0;
    wr_pos     = pos_r[5:0];
    wr_byte    = 8'h00;
    rd_en      = 1'b0;
    rd_addr    = 4'd0;

    unique case (state_r)
      StIdle: begin
        if (in_acc) begin
          wr_en  = 1'b1;
          wr_pos = fill_r;
          if (!in_kind) begin
            wr_byte  = in_data_byte;
            fill_nxt = fill_r + 6'd1;
            if (fill_r == 6'd63) begin
              state_nxt = StLoad;
              ret_nxt   = RetIdle;
            end
          end else begin
            // Pad marker, then zeros; an extra block when the length
            // no longer fits behind it.
            wr_byte   = PadByte;
            len_nxt   = total_r + {55'd0, fill_r, 3'b000};
            pos_nxt   = {1'b0, fill_r} + 7'd1;
            extra_nxt = (fill_r >= 6'(LenStart));
            state_nxt = StPad;
          end
        end
      end
      StPad: begin
        if (extra_r) begin
          if (pos_r[6]) begin
            state_nxt = StLoad;
            ret_nxt   = RetPad;
            pos_nxt   = 7'd0;
            extra_nxt = 1'b0;
          end else begin
            wr_en   = 1'b1;
            pos_nxt = pos_r + 7'd1;
          end
        end else begin
          wr_en   = 1'b1;
          pos_nxt = pos_r + 7'd1;
          if (pos_r >= 7'(LenStart)) begin
            wr_byte = len_r[{len_sel, 3'b000} +: 8];
          end
          if (pos_r == 7'd63) begin
            state_nxt = StLoad;
            ret_nxt   = RetOut;
          end
        end
      end
      StLoad: begin
        rd_en     = 1'b1;
        rd_addr   = 4'd0;
        v_nxt     = h_r;
        rnd_nxt   = 6'd0;
        state_nxt = StComp;
      end
      StComp: begin
        rd_en   = 1'b1;
        rd_addr = rnd_r[3:0] + 4'd1;
        v_nxt   = v_rnd;
        win_nxt = {w_t, win_r[15:1]};
        rnd_nxt = rnd_r + 6'd1;
        if (rnd_r == 6'(Rounds - 1)) begin
          state_nxt = StFold;
        end
      end
      StFold: begin
        for (int i = 0; i < 8; i++) begin
          h_nxt[i] = h_r[i] + v_r[i];
        end
        unique case (ret_r)
          RetIdle: begin
            total_nxt = total_r + BlockBits;
            state_nxt = StIdle;
          end
          RetPad: begin
            state_nxt = StPad;
          end
          RetOut: begin
            idx_nxt    = 3'd0;
            ovalid_nxt = 1'b1;
            state_nxt  = StOut;
          end
          default: begin
            state_nxt = StIdle;
          end
        endcase
      end
      StOut: begin
        if (!out_stall) begin
          idx_nxt = idx_r + 3'd1;
          if (idx_r == 3'd7) begin
            ovalid_nxt = 1'b0;
            h_nxt      = InitHash;
            total_nxt  = 64'd0;
            fill_nxt   = 6'd0;
            state_nxt  = StIdle;
          end
        end
      end
      default: begin
        state_nxt = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= StIdle;
      ret_r    <= RetIdle;
      fill_r   <= 6'd0;
      total_r  <= 64'd0;
      extra_r  <= 1'b0;
      idx_r    <= 3'd0;
      ovalid_r <= 1'b0;
      h_r      <= InitHash;
    end else begin
      state_r  <= state_nxt;
      ret_r    <= ret_nxt;
      fill_r   <= fill_nxt;
      total_r  <= total_nxt;
      extra_r  <= extra_nxt;
      idx_r    <= idx_nxt;
      ovalid_r <= ovalid_nxt;
      h_r      <= h_nxt;
    end
  end

  always_ff @(posedge clk) begin
    len_r <= len_nxt;
    pos_r <= pos_nxt;
    rnd_r <= rnd_nxt;
    v_r   <= v_nxt;
    win_r <= win_nxt;
  end

endmodule

`default_nettype wire

### rtl/s256_checker.sv
// ----------------------------------------------------------------------------
// s256_checker
// Port-level checks on the SHA-256 hasher, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module s256_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  out_word_index,
  input logic        out_last,
  input logic [31:0] out_digest_word
);

  // No new request is taken while a digest is being offered.
  a_stall_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input accepted during digest output");

  // Words leave in order: an accepted non-final word is followed by the next.
  a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !out_last) |=>
      (out_valid && out_word_index == $past(out_word_index) + 3'd1))
    else $error("digest word index did not advance");

  // The final word closes the digest.
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_last) |=> !out_valid)
    else $error("output still valid after final word");

  // A stalled word holds.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_digest_word)))
    else $error("stalled digest word changed");

endmodule

bind sha256_stream_hasher s256_checker u_s256_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_word_index  (out_word_index),
  .out_last        (out_last),
  .out_digest_word (out_digest_word)
);

`default_nettype wire
